@@ hdl/opt_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// opt_pkg: shared types and codes for the oscillation phase trigger
// Phase codes, detect type codes and configuration register indexes.
// ----------------------------------------------------------------------------
package opt_pkg;

    // width of the configuration address bus (five 32-bit registers)
    localparam int ADDR_BITS = 5;
    localparam int DATA_BITS = 32;

    // oscillation phase, encoded so that detect type n selects phase n
    typedef enum logic [2:0] {
        PH_NONE     = 3'd0,
        PH_FALL_POS = 3'd1,
        PH_FALL_NEG = 3'd2,
        PH_RISE_NEG = 3'd3,
        PH_RISE_POS = 3'd4
    } phase_t;

    // detect type codes
    localparam logic [2:0] DET_NONE      = 3'd0;
    localparam logic [2:0] DET_PEAK      = 3'd1;
    localparam logic [2:0] DET_FALL_THR  = 3'd2;
    localparam logic [2:0] DET_TROUGH    = 3'd3;
    localparam logic [2:0] DET_RISE_ZERO = 3'd4;

    // configuration register indexes (byte address is 4 * index)
    localparam logic [2:0] REG_DETECT_TYPE       = 3'd0;
    localparam logic [2:0] REG_GATE_CHANNEL      = 3'd1;
    localparam logic [2:0] REG_PULSE_LENGTH      = 3'd2;
    localparam logic [2:0] REG_FALLING_THRESHOLD = 3'd3;
    localparam logic [2:0] REG_CHANNEL_ENABLE    = 3'd4;

    // item operation codes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_GATE   = 1'b1;

    // reset values of the configuration registers and the trigger counter
    localparam logic [15:0] PULSE_LENGTH_RESET  = 16'd1000;
    localparam logic [4:0]  GATE_CHANNEL_RESET  = 5'h1f;
    localparam int          FALL_THRESHOLD_RESET = -2000;
    localparam int          COUNT_RESET_LIMIT   = 5000;

endpackage : opt_pkg
`default_nettype wire

@@ hdl/oscillation_phase_trigger.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// oscillation_phase_trigger: phase detector with pulse edge output
// Tracks the phase of a sampled oscillation and emits pulse edges when the
// selected phase is entered and when the pulse length runs out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (s_*): one item per valid/ready handshake, either a signed
//   sample (s_op = 0) or a gate event (s_op = 1).
//   Result channel (m_*): zero or one item per input item, carrying the pulse
//   edge level (1 rising on trigger, 0 falling at pulse end).
//   Configuration: APB-style port, registers at byte address 4 * index,
//   pready always high; write only while the block is idle.
//   Path: an accepted item is held in the input register; once the output
//   register is free or being emptied, its result is loaded into the output
//   register, which drives m_valid.
//   Throughput: one item per cycle while the output is free or m_ready is
//   high; the phase/counter update is one compare/update pass on the state registers.
//   Stall: when m_ready is low the output register holds its item; the input
//   register still accepts one more item, then s_ready drops until the
//   result is taken.
//   Reset (aresetn low, synchronous): both channels empty, configuration and
//   tracking state back to their defaults.
// ----------------------------------------------------------------------------
module oscillation_phase_trigger
    import opt_pkg::*;
#(
    parameter int SAMPLE_BITS = 24,
    parameter int COUNT_BITS  = 17
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // input channel
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_op,
    input  wire logic signed [SAMPLE_BITS-1:0] s_sample_value,
    input  wire logic [3:0]                    s_event_channel,
    input  wire logic                          s_event_level,
    // result channel
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic                               m_pulse_level,
    // configuration port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [ADDR_BITS-1:0]          paddr,
    input  wire logic [DATA_BITS-1:0]          pwdata,
    output logic [DATA_BITS-1:0]               prdata,
    output logic                               pready
);

    // counter limits
    localparam logic [COUNT_BITS-1:0] COUNT_MAX   = '1;
    localparam logic [COUNT_BITS-1:0] COUNT_RESET = (COUNT_BITS >= 13) ?
        COUNT_BITS'(COUNT_RESET_LIMIT) : COUNT_MAX;
    localparam int CMP_BITS = (COUNT_BITS > 16) ? COUNT_BITS : 16;

    // configuration registers
    logic [2:0]                    detect_type_reg;
    logic signed [4:0]             gate_channel_reg;
    logic [15:0]                   pulse_length_reg;
    logic signed [SAMPLE_BITS-1:0] falling_threshold_reg;
    logic                          channel_enable_reg;

    // tracking state
    logic signed [SAMPLE_BITS-1:0] prev_sample_reg, prev_sample_next;
    phase_t                        phase_reg, phase_next;
    logic [COUNT_BITS-1:0]         since_trigger_reg, since_trigger_next;
    logic                          pulse_high_reg, pulse_high_next;
    logic                          active_reg, active_next;

    // input register
    logic                          in_valid_reg;
    logic                          in_op_reg;
    logic signed [SAMPLE_BITS-1:0] in_sample_reg;
    logic [3:0]                    in_channel_reg;
    logic                          in_level_reg;

    // output register
    logic                          out_valid_reg;
    logic                          out_level_reg;

    // processing control
    logic       proc_fire;
    logic       res_valid;
    logic       res_level;
    logic       cfg_write;
    logic [2:0] cfg_index;
    phase_t     rule_phase;
    logic [2:0] target_code;
    logic       count_expired;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[ADDR_BITS-1:2];

    // the stored item is processed once the output slot can take a result
    assign proc_fire = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || proc_fire;
    assign m_valid   = out_valid_reg;
    assign m_pulse_level = out_level_reg;

    // register readback
    always_comb begin
        prdata = '0;
        case (cfg_index)
            REG_DETECT_TYPE:       prdata = DATA_BITS'(detect_type_reg);
            REG_GATE_CHANNEL:      prdata = DATA_BITS'(gate_channel_reg);
            REG_PULSE_LENGTH:      prdata = DATA_BITS'(pulse_length_reg);
            REG_FALLING_THRESHOLD: prdata = DATA_BITS'(falling_threshold_reg);
            REG_CHANNEL_ENABLE:    prdata = DATA_BITS'(channel_enable_reg);
            default:               prdata = '0;
        endcase
    end

    // phase rules in priority order; a rule naming the current phase is skipped
    always_comb begin
        rule_phase = PH_NONE;
        if (in_sample_reg < prev_sample_reg && in_sample_reg > 0 &&
            phase_reg != PH_FALL_POS) begin
            rule_phase = PH_FALL_POS;
        end else if (in_sample_reg < falling_threshold_reg &&
                     prev_sample_reg >= falling_threshold_reg &&
                     phase_reg != PH_FALL_NEG) begin
            rule_phase = PH_FALL_NEG;
        end else if (in_sample_reg > prev_sample_reg && in_sample_reg < 0 &&
                     phase_reg != PH_RISE_NEG) begin
            rule_phase = PH_RISE_NEG;
        end else if (in_sample_reg > 0 && prev_sample_reg <= 0 &&
                     phase_reg != PH_RISE_POS) begin
            rule_phase = PH_RISE_POS;
        end
    end

    // detect types outside peak..rising zero never trigger
    assign target_code = (detect_type_reg >= DET_PEAK && detect_type_reg <= DET_RISE_ZERO) ?
                         detect_type_reg : DET_NONE;
    assign count_expired = CMP_BITS'(since_trigger_reg) > CMP_BITS'(pulse_length_reg);

    // next state and result for the stored item
    always_comb begin
        prev_sample_next   = prev_sample_reg;
        phase_next         = phase_reg;
        since_trigger_next = since_trigger_reg;
        pulse_high_next    = pulse_high_reg;
        active_next        = active_reg;
        res_valid          = 1'b0;
        res_level          = 1'b0;
        if (in_op_reg == OP_GATE) begin
            // negative gate channel has its sign bit set and never matches
            if (gate_channel_reg == {1'b0, in_channel_reg}) begin
                active_next = in_level_reg;
            end
        end else if (active_reg && channel_enable_reg) begin
            prev_sample_next = in_sample_reg;
            if (rule_phase != PH_NONE) begin
                phase_next = rule_phase;
            end
            if (rule_phase != PH_NONE && rule_phase == target_code) begin
                // trigger: rising edge, counter restarts and counts this sample
                pulse_high_next    = 1'b1;
                since_trigger_next = COUNT_BITS'(1);
                res_valid          = 1'b1;
                res_level          = 1'b1;
            end else if (pulse_high_reg) begin
                if (count_expired) begin
                    pulse_high_next = 1'b0;
                    res_valid       = 1'b1;
                    res_level       = 1'b0;
                end else if (since_trigger_reg != COUNT_MAX) begin
                    since_trigger_next = since_trigger_reg + COUNT_BITS'(1);
                end
            end
        end
    end

    // control, configuration and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg          <= 1'b0;
            out_valid_reg         <= 1'b0;
            detect_type_reg       <= DET_NONE;
            gate_channel_reg      <= GATE_CHANNEL_RESET;
            pulse_length_reg      <= PULSE_LENGTH_RESET;
            falling_threshold_reg <= SAMPLE_BITS'(FALL_THRESHOLD_RESET);
            channel_enable_reg    <= 1'b0;
            prev_sample_reg       <= '0;
            phase_reg             <= PH_NONE;
            since_trigger_reg     <= COUNT_RESET;
            pulse_high_reg        <= 1'b0;
            active_reg            <= 1'b1;
        end else begin
            // input register
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            // output register
            if (proc_fire) begin
                out_valid_reg <= res_valid;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            // state update per processed item
            if (proc_fire) begin
                prev_sample_reg   <= prev_sample_next;
                phase_reg         <= phase_next;
                since_trigger_reg <= since_trigger_next;
                pulse_high_reg    <= pulse_high_next;
                active_reg        <= active_next;
            end
            // configuration writes; the user must write only while idle, the block does not enforce it
            if (cfg_write) begin
                case (cfg_index)
                    REG_DETECT_TYPE: detect_type_reg <= pwdata[2:0];
                    REG_GATE_CHANNEL: begin
                        gate_channel_reg <= pwdata[4:0];
                        active_reg       <= pwdata[4];
                    end
                    REG_PULSE_LENGTH:      pulse_length_reg <= pwdata[15:0];
                    REG_FALLING_THRESHOLD: falling_threshold_reg <= pwdata[SAMPLE_BITS-1:0];
                    REG_CHANNEL_ENABLE:    channel_enable_reg <= pwdata[0];
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_op_reg      <= s_op;
            in_sample_reg  <= s_sample_value;
            in_channel_reg <= s_event_channel;
            in_level_reg   <= s_event_level;
        end
        if (proc_fire && res_valid) begin
            out_level_reg <= res_level;
        end
    end

    // a rising edge result leaves the pulse high
    assert property (@(posedge aclk) disable iff (!aresetn)
        proc_fire && res_valid && res_level |=> pulse_high_reg)
        else $error("pulse not high after rising edge");

    // a falling edge result only ends a pulse that was high
    assert property (@(posedge aclk) disable iff (!aresetn)
        proc_fire && res_valid && !res_level |-> pulse_high_reg)
        else $error("falling edge without a pulse");

    // the trigger counter never reads zero while the pulse is high
    assert property (@(posedge aclk) disable iff (!aresetn)
        pulse_high_reg |-> since_trigger_reg != '0)
        else $error("trigger counter zero during pulse");

    // a disabled sample item leaves the tracked sample unchanged
    assert property (@(posedge aclk) disable iff (!aresetn)
        proc_fire && in_op_reg == OP_SAMPLE && !channel_enable_reg && !cfg_write
        |=> $stable(prev_sample_reg))
        else $error("disabled sample changed tracking state");

endmodule : oscillation_phase_trigger
`default_nettype wire
